// ===== design/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the greedy rectangle cover
// Cell codes, request and response payloads, sequencer states, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package grc_pkg;

  // Tile cell codes as held in the grid memory
  typedef enum logic [1:0] {
    CELL_FREE  = 2'd0,
    CELL_SOLID = 2'd1,
    CELL_DONE  = 2'd2
  } cell_e;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [6:0] COLS_RST = 7'd34;
  localparam logic [5:0] ROWS_RST = 6'd23;

  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic       req_type;
    logic [5:0] cell_col;
    logic [4:0] cell_row;
    logic       cell_solid;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [11:0] left_px;
    logic [9:0]         top_px;
    logic [11:0]        width_px;
    logic [10:0]        height_px;
    logic [10:0]        rect_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_MOD,
    S_FT_RD,
    S_SCAN,
    S_RUN,
    S_DN_RD,
    S_DN_CHK,
    S_OUT
  } state_e;

endpackage

// ===== design/grc_row_mem.sv =====
// ----------------------------------------------------------------------------
// grc_row_mem: grid row memory
// One row of cells per entry, one read and one write port, registered read.
// A row never written since reset reads as all free through its valid bit.
// ----------------------------------------------------------------------------
module grc_row_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 128,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten rows read as free
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/greedy_rectangle_cover.sv =====
// ----------------------------------------------------------------------------
// greedy_rectangle_cover: greedy rectangle cover of a tile grid
// Keeps a grid of free / occupied / covered tile cells and hands out the
// occupied area as rectangles in pixels, one per fetch transaction.
// ----------------------------------------------------------------------------
// A user sends one transaction at a time on the input channel: a write sets
// one cell to free or occupied and rewinds the scan cursor and the rectangle
// count; in the grid it reads the row on accept, then writes it back, and
// gives no result. A fetch walks the grid in row-major order from the
// cursor, one cell per cycle, to the next occupied cell, grows the run to
// the right one cell per cycle, then for each row below reads the row,
// tests that the whole span is occupied and marks it covered until the
// span breaks, and returns one result transaction with the rectangle in
// pixels (or found low once nothing occupied remains). The block is not
// ready while a transaction is in work. The grid comes out of reset all
// free without a clearing pass: each row has a valid bit that reset
// clears. Configuration writes (column and row counts) are taken at any
// cycle with the write enable high and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module greedy_rectangle_cover
  import grc_pkg::*;
#(
  parameter int unsigned GRID_W  = 64,
  parameter int unsigned GRID_H  = 32,
  parameter int unsigned TILE_PX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Counter widths hold one past the last column / row
  localparam int unsigned CW  = $clog2(GRID_W + 1);
  localparam int unsigned RW  = $clog2(GRID_H + 1);
  localparam int unsigned CIW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int unsigned RIW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int unsigned CFW = (CW > 7) ? CW : 7;
  localparam int unsigned RFW = (RW > 6) ? RW : 6;

  typedef logic [GRID_W-1:0][1:0] row_t;

  state_e        state_q, state_d;
  logic [6:0]    cols_q;
  logic [5:0]    rows_q;
  logic [CW-1:0] nc;
  logic [RW-1:0] nr;

  logic [CW-1:0] scan_col_q, scan_col_d;
  logic [RW-1:0] scan_row_q, scan_row_d;
  logic [10:0]   rect_count_q, rect_count_d;
  logic [CW-1:0] c0_q, c0_d;
  logic [CW-1:0] w_q, w_d;
  logic [RW-1:0] h_q, h_d;
  logic [RW-1:0] dn_row_q, dn_row_d;
  logic          found_q, found_d;
  req_t          req_q, req_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q, out_d;

  logic           mem_rd_en, mem_wr_en;
  logic [RIW-1:0] mem_rd_addr, mem_wr_addr;
  row_t           mem_wr_data;
  row_t           rdata;

  logic [CW:0]   run_end;
  logic [CW:0]   span_end;
  row_t          span_row;
  logic          span_ok;
  row_t          wr_row;
  logic          wr_in_grid;

  logic [31:0]   left_full, top_full, width_full, height_full;
  logic [CW+1:0] wt;

  // --------------------------------------------------------------------------
  // Effective scan limits: counts above the grid act as the grid size
  // --------------------------------------------------------------------------
  assign nc = (CFW'(cols_q) > CFW'(GRID_W)) ? CW'(GRID_W) : CW'(cols_q);
  assign nr = (RFW'(rows_q) > RFW'(GRID_H)) ? RW'(GRID_H) : RW'(rows_q);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLS: cols_q <= cfg_wdata_i[6:0];
        CFG_ROWS: rows_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Grid row memory
  // --------------------------------------------------------------------------
  grc_row_mem #(
    .DEPTH (GRID_H),
    .WIDTH (2 * GRID_W),
    .AW    (RIW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (rdata),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // --------------------------------------------------------------------------
  // Span logic over the row held in the read register: check that every
  // cell of the span [c0, c0+w) is occupied, and build the row with the span
  // marked covered. Columns are independent of each other.
  // --------------------------------------------------------------------------
  assign run_end  = (CW + 1)'(c0_q) + (CW + 1)'(w_q);
  assign span_end = run_end;

  always_comb begin
    span_row = rdata;
    span_ok  = 1'b1;
    for (int j = 0; j < GRID_W; j++) begin
      if (((CW + 1)'(j) >= (CW + 1)'(c0_q)) && ((CW + 1)'(j) < span_end)) begin
        if (rdata[j] != CELL_SOLID) begin
          span_ok = 1'b0;
        end
        span_row[j] = CELL_DONE;
      end
    end
  end

  // Row image for a single-cell write
  assign wr_in_grid = (32'(req_q.cell_col) < GRID_W) && (32'(req_q.cell_row) < GRID_H);

  always_comb begin
    wr_row = rdata;
    wr_row[CIW'(req_q.cell_col)] = req_q.cell_solid ? CELL_SOLID : CELL_FREE;
  end

  // --------------------------------------------------------------------------
  // Pixel results: constant multiplies by the tile size, then truncate
  // to the field widths. The right edge is reached when c0 + w equals nc.
  // --------------------------------------------------------------------------
  always_comb begin
    wt = (CW + 2)'(w_q)
       + (CW + 2)'(c0_q == '0)
       + (CW + 2)'(run_end >= (CW + 1)'(nc));
    left_full   = (c0_q == '0) ? (32'd0 - 32'(TILE_PX)) : 32'(c0_q) * 32'(TILE_PX);
    top_full    = 32'(scan_row_q) * 32'(TILE_PX);
    width_full  = 32'(wt) * 32'(TILE_PX);
    height_full = 32'(h_q) * 32'(TILE_PX);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      rect_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_col_q   <= scan_col_d;
      scan_row_q   <= scan_row_d;
      rect_count_q <= rect_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working registers of the transaction in flight
  always_ff @(posedge clk_i) begin
    c0_q     <= c0_d;
    w_q      <= w_d;
    h_q      <= h_d;
    dn_row_q <= dn_row_d;
    found_q  <= found_d;
    req_q    <= req_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    scan_col_d   = scan_col_q;
    scan_row_d   = scan_row_q;
    rect_count_d = rect_count_q;
    c0_d         = c0_q;
    w_d          = w_q;
    h_d          = h_q;
    dn_row_d     = dn_row_q;
    found_d      = found_q;
    req_d        = req_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = RIW'(scan_row_q);
    mem_wr_en    = 1'b0;
    mem_wr_addr  = RIW'(scan_row_q);
    mem_wr_data  = span_row;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.req_type == REQ_WRITE) begin
            // Rewind the cursor and the count on every write
            scan_col_d   = '0;
            scan_row_d   = '0;
            rect_count_d = '0;
            if ((32'(in_data_i.cell_col) < GRID_W) && (32'(in_data_i.cell_row) < GRID_H)) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = RIW'(in_data_i.cell_row);
              state_d     = S_WR_MOD;
            end
          end else begin
            state_d = S_FT_RD;
          end
        end
      end

      S_WR_MOD: begin
        mem_wr_en   = wr_in_grid;
        mem_wr_addr = RIW'(req_q.cell_row);
        mem_wr_data = wr_row;
        state_d     = S_IDLE;
      end

      S_FT_RD: begin
        if (scan_row_q < nr) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = RIW'(scan_row_q);
          state_d     = S_SCAN;
        end else begin
          // Nothing left: park the cursor at the end of the scanned area
          scan_col_d = '0;
          found_d    = 1'b0;
          state_d    = S_OUT;
        end
      end

      S_SCAN: begin
        if (scan_col_q >= nc) begin
          scan_row_d = scan_row_q + RW'(1);
          scan_col_d = '0;
          state_d    = S_FT_RD;
        end else if (rdata[CIW'(scan_col_q)] == CELL_SOLID) begin
          c0_d       = scan_col_q;
          w_d        = CW'(1);
          scan_col_d = scan_col_q + CW'(1);
          state_d    = S_RUN;
        end else begin
          scan_col_d = scan_col_q + CW'(1);
        end
      end

      S_RUN: begin
        if ((run_end < (CW + 1)'(nc)) && (rdata[CIW'(run_end)] == CELL_SOLID)) begin
          w_d = w_q + CW'(1);
        end else begin
          // Mark the first row of the rectangle covered
          mem_wr_en   = 1'b1;
          mem_wr_addr = RIW'(scan_row_q);
          mem_wr_data = span_row;
          h_d         = RW'(1);
          dn_row_d    = scan_row_q + RW'(1);
          state_d     = S_DN_RD;
        end
      end

      S_DN_RD: begin
        if (dn_row_q < nr) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = RIW'(dn_row_q);
          state_d     = S_DN_CHK;
        end else begin
          found_d = 1'b1;
          state_d = S_OUT;
        end
      end

      S_DN_CHK: begin
        if (span_ok) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = RIW'(dn_row_q);
          mem_wr_data = span_row;
          h_d         = h_q + RW'(1);
          dn_row_d    = dn_row_q + RW'(1);
          state_d     = S_DN_RD;
        end else begin
          found_d = 1'b1;
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.found      = found_q;
          out_d.rect_index = rect_count_q;
          if (found_q) begin
            out_d.left_px   = left_full[11:0];
            out_d.top_px    = top_full[9:0];
            out_d.width_px  = width_full[11:0];
            out_d.height_px = height_full[10:0];
            if (rect_count_q != COUNT_MAX) begin
              rect_count_d = rect_count_q + 11'd1;
            end
          end else begin
            out_d.left_px   = '0;
            out_d.top_px    = '0;
            out_d.width_px  = '0;
            out_d.height_px = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The row memory is read-modify-write: never read and write in one cycle
  a_mem_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> !mem_rd_en)
    else $error("row memory read and written in the same cycle");

  // A finished rectangle lies inside the scanned columns and is not empty
  a_rect_in_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && found_q) |->
      (run_end <= (CW + 1)'(nc)) && (w_q != '0) && (h_q != '0))
    else $error("rectangle outside the scanned area");

  // The cell walker only runs on a row inside the scanned area
  a_scan_row_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_RUN) |-> (scan_row_q < nr))
    else $error("scan row beyond the scanned rows");

  // The rectangle count saturates and only a write clears it
  a_count_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rect_count_q == COUNT_MAX &&
     !(in_valid_i && in_ready_o && in_data_i.req_type == REQ_WRITE)) |=>
      (rect_count_q == COUNT_MAX))
    else $error("rectangle count left saturation");

endmodule

// ===== tb/sv/rect_cover_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_cover_checker: result checker for the greedy rectangle cover
// Follows cell writes, fetches and register writes as they are accepted,
// keeps its own tile grid and scan cursor, predicts every fetch result and
// compares each result transaction field by field.
// ----------------------------------------------------------------------------
module rect_cover_checker
  import grc_pkg::*;
#(
  parameter int COLS_MAX  = 64,
  parameter int ROWS_MAX  = 32,
  parameter int TILE_SIZE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  req_t                  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  rsp_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    rects_due_o,
  output int                    fail_count_o
);

  cell_e       tile_map [ROWS_MAX][COLS_MAX];
  int          cur_row;
  int          cur_col;
  logic [10:0] rects_since_write;
  logic [6:0]  cols_cfg;
  logic [5:0]  rows_cfg;
  rsp_t        rects_due [$];
  int          fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    fails++;
  endtask

  // Find the next occupied cell from the cursor, grow right then down,
  // mark what is taken and return the rectangle in pixels.
  function automatic rsp_t cover_next_rect();
    int   nc, nr, r, c, w, h, k;
    int   left, width, top, height;
    logic span_ok;
    rsp_t res;
    nc = int'(cols_cfg);
    nr = int'(rows_cfg);
    if (nc > COLS_MAX) nc = COLS_MAX;
    if (nr > ROWS_MAX) nr = ROWS_MAX;
    res = '0;
    res.rect_index = rects_since_write;
    r = cur_row;
    c = cur_col;
    while (r < nr) begin
      if (c >= nc) begin
        r++;
        c = 0;
      end else if (tile_map[r][c] == CELL_SOLID) begin
        break;
      end else begin
        c++;
      end
    end
    if (r >= nr) begin
      cur_row = r;
      cur_col = 0;
      return res;
    end

    tile_map[r][c] = CELL_DONE;
    w = 1;
    while (c + w < nc && tile_map[r][c + w] == CELL_SOLID) begin
      tile_map[r][c + w] = CELL_DONE;
      w++;
    end
    h = 1;
    span_ok = 1'b1;
    while (span_ok && r + h < nr) begin
      for (k = 0; k < w; k++)
        if (tile_map[r + h][c + k] != CELL_SOLID) span_ok = 1'b0;
      if (span_ok) begin
        for (k = 0; k < w; k++) tile_map[r + h][c + k] = CELL_DONE;
        h++;
      end
    end

    left   = c * TILE_SIZE;
    width  = w * TILE_SIZE;
    top    = r * TILE_SIZE;
    height = h * TILE_SIZE;
    if (c == 0) begin
      left  = -TILE_SIZE;
      width = width + TILE_SIZE;
    end
    if (left + width >= nc * TILE_SIZE) width = width + TILE_SIZE;

    res.found     = 1'b1;
    res.left_px   = left[11:0];
    res.top_px    = top[9:0];
    res.width_px  = width[11:0];
    res.height_px = height[10:0];
    if (rects_since_write != COUNT_MAX) rects_since_write++;
    cur_row = r;
    cur_col = c + 1;
    return res;
  endfunction

  task automatic check_rect(input rsp_t got);
    rsp_t want;
    if (rects_due.size() == 0) begin
      report_mismatch("result transaction with no fetch outstanding");
      return;
    end
    want = rects_due.pop_front();
    if (got.found !== want.found)
      report_mismatch($sformatf("found %0b, predicted %0b", got.found, want.found));
    if (got.left_px !== want.left_px)
      report_mismatch($sformatf("left_px %0d, predicted %0d", got.left_px, want.left_px));
    if (got.top_px !== want.top_px)
      report_mismatch($sformatf("top_px %0d, predicted %0d", got.top_px, want.top_px));
    if (got.width_px !== want.width_px)
      report_mismatch($sformatf("width_px %0d, predicted %0d", got.width_px, want.width_px));
    if (got.height_px !== want.height_px)
      report_mismatch($sformatf("height_px %0d, predicted %0d",
                                got.height_px, want.height_px));
    if (got.rect_index !== want.rect_index)
      report_mismatch($sformatf("rect_index %0d, predicted %0d",
                                got.rect_index, want.rect_index));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS_MAX; r++)
        for (int c = 0; c < COLS_MAX; c++) tile_map[r][c] = CELL_FREE;
      cur_row           = 0;
      cur_col           = 0;
      rects_since_write = '0;
      cols_cfg          = COLS_RST;
      rows_cfg          = ROWS_RST;
      rects_due.delete();
      rects_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_COLS) cols_cfg = cfg_wdata_i[6:0];
        else if (cfg_idx_i == CFG_ROWS) rows_cfg = cfg_wdata_i[5:0];
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.req_type == REQ_WRITE) begin
          tile_map[in_data_i.cell_row][in_data_i.cell_col] =
            in_data_i.cell_solid ? CELL_SOLID : CELL_FREE;
          cur_row           = 0;
          cur_col           = 0;
          rects_since_write = '0;
        end else begin
          rects_due = {rects_due, cover_next_rect()};
        end
      end
      if (out_valid_i && out_ready_i) check_rect(out_data_i);
      rects_due_o <= rects_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the greedy rectangle cover
// Drives cell writes and fetches with bursty valid, stalls the result side,
// steps the column and row counts through small, edge and oversized values,
// and lets the checker judge every result transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import grc_pkg::*;

  localparam int ITEM_TARGET   = 950;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 10;     // covers the row write-back of a last write
  localparam int N_FIXED       = 7;

  // Result-side stall styles
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_MASK   = 2;
  localparam int RX_BURSTY = 3;
  localparam logic [15:0] RX_MASK_BITS = 16'hB3C5;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_COLS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int         rects_due;
  int         fail_count;
  int         burst_left   = 0;
  int         sent_items   = 0;
  int         quiet_cycles = 0;
  logic [5:0] rx_tick      = '0;
  int         rx_mode      = RX_ALWAYS;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  greedy_rectangle_cover dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  rect_cover_checker u_rect_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rects_due_o (rects_due),
    .fail_count_o(fail_count)
  );

  // Result side: pick a new stall style each time the tick counter wraps; one
  // of them never stalls, so long stretches of back-to-back results happen too.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_tick   <= '0;
      rx_mode   <= RX_ALWAYS;
    end else begin
      rx_tick <= rx_tick + 6'd1;
      if (rx_tick == 6'd0) rx_mode <= int'($urandom_range(RX_ALWAYS, RX_BURSTY));
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_MASK:   out_ready <= RX_MASK_BITS[rx_tick[3:0]];
        default:   out_ready <= (rx_tick[5:3] != 3'd0);
      endcase
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("greedy_rectangle_cover verification failed");
        $finish;
      end
    end
  end

  // Offer one request transaction. Requests go out in bursts; between bursts
  // drop valid for a random gap, but never drop and raise it in one step.
  task automatic send_req(input req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_items++;
  endtask

  task automatic write_cell(input int col, input int row, input int solid);
    req_t req;
    req.req_type   = REQ_WRITE;
    req.cell_col   = col[5:0];
    req.cell_row   = row[4:0];
    req.cell_solid = solid[0];
    send_req(req);
  endtask

  // The cell fields are don't-care on a fetch: fill them with noise.
  task automatic fetch_rect();
    req_t req;
    req.req_type   = REQ_FETCH;
    req.cell_col   = 6'($urandom_range(0, 63));
    req.cell_row   = 5'($urandom_range(0, 31));
    req.cell_solid = 1'($urandom_range(0, 1));
    send_req(req);
  endtask

  // Change the column and row counts only once the block has drained: wait
  // for every predicted result, then let a trailing cell write finish.
  task automatic load_setting(input int cols, input int rows);
    logic [6:0] rows_word;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rects_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    rows_word    = rows[6:0];
    rows_word[6] = 1'($urandom_range(0, 1));  // above the register width
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_COLS;
    cfg_wdata <= cols[6:0];
    @(posedge clk);
    cfg_idx   <= CFG_ROWS;
    cfg_wdata <= rows_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int cols, rows, nc, nr, phase, phase_end;
    int n_rect, rw, rh, x0, y0, n_fetch;
    bit big;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset counts (34 columns, 23 rows).
    write_cell(0, 0, 1);     // two-wide run on the left edge
    write_cell(1, 0, 1);
    write_cell(0, 1, 1);     // below it, only part of the span: no extension
    write_cell(10, 2, 1);    // 2x2 block with a partial row under it
    write_cell(11, 2, 1);
    write_cell(10, 3, 1);
    write_cell(11, 3, 1);
    write_cell(10, 4, 1);
    write_cell(33, 22, 1);   // last scanned column and row: right edge
    write_cell(63, 31, 1);   // far corner, outside the scanned area
    write_cell(40, 5, 1);    // beyond the column count
    repeat (7) fetch_rect(); // five rectangles, then nothing, cursor parked
    write_cell(0, 0, 0);     // free a covered cell, rewind the count
    fetch_rect();
    write_cell(5, 0, 1);
    fetch_rect();
    fetch_rect();

    // Random part: phases of column/row settings, each filled with scenes
    // of rectangles drawn as cell writes, then drained by fetches.
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase)
        0: begin cols = 1;   rows = 1;  end
        1: begin cols = 64;  rows = 32; end
        2: begin cols = 127; rows = 63; end
        3: begin cols = 0;   rows = 6;  end
        4: begin cols = 9;   rows = 0;  end
        5: begin cols = 1;   rows = 32; end
        6: begin cols = 64;  rows = 1;  end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            cols = $urandom_range(64, 127);
            rows = $urandom_range(32, 63);
          end else begin
            cols = $urandom_range(1, 16);
            rows = $urandom_range(1, 10);
          end
        end
      endcase
      load_setting(cols, rows);
      nc  = (cols > 64) ? 64 : cols;
      nr  = (rows > 32) ? 32 : rows;
      big = (nc > 16);
      phase_end = sent_items + $urandom_range(30, 60);

      while (sent_items < phase_end && sent_items < ITEM_TARGET) begin
        if (nc == 0 || nr == 0) begin
          // Nothing is scanned: writes anywhere, fetches find nothing.
          repeat ($urandom_range(1, 3))
            write_cell($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 1));
          repeat ($urandom_range(1, 3)) fetch_rect();
        end else begin
          n_rect = $urandom_range(1, 3);
          for (int i = 0; i < n_rect; i++) begin
            if (big && $urandom_range(0, 3) == 0) begin
              // full-width band: touches both edges
              rw = nc;
              x0 = 0;
              rh = $urandom_range(1, (nr < 2) ? nr : 2);
            end else begin
              rw = $urandom_range(1, (nc < 5) ? nc : 5);
              rh = $urandom_range(1, (nr < 4) ? nr : 4);
              case ($urandom_range(0, 3))
                0:       x0 = 0;
                1:       x0 = nc - rw;
                default: x0 = $urandom_range(0, nc - rw);
              endcase
            end
            y0 = $urandom_range(0, nr - rh);
            for (int y = 0; y < rh; y++)
              for (int x = 0; x < rw; x++) write_cell(x0 + x, y0 + y, 1);
          end
          // Punch holes or add strays inside the area, and now and then
          // touch a cell anywhere in the grid.
          repeat ($urandom_range(0, 2))
            write_cell($urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
                       $urandom_range(0, 1));
          if ($urandom_range(0, 3) == 0)
            write_cell($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 1));
          // Drain with enough fetches to run past the last rectangle; a
          // rare write in between rewinds the cursor mid-scan.
          n_fetch = 2 * n_rect + $urandom_range(1, 3);
          for (int k = 0; k < n_fetch; k++) begin
            if ($urandom_range(0, 11) == 0)
              write_cell($urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
                         $urandom_range(0, 1));
            fetch_rect();
          end
        end
      end
      phase++;
    end

    // Drain: hold valid low, wait for the last result, then a short tail.
    in_valid <= 1'b0;
    @(posedge clk);
    while (rects_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("greedy_rectangle_cover verification clean");
    end else begin
      $display("greedy_rectangle_cover verification failed");
    end
    $finish;
  end

endmodule
